FILE: design/slt_pkg.sv
// Shared constants and types for the Sauvola local threshold block.
package slt_pkg;

  // Frame and window limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WINDOW = 127;
  localparam int RING_ROWS  = 128;
  localparam int LS_DEPTH   = MAX_WIDTH * RING_ROWS;
  localparam int LS_AW      = 17;

  // Shared divider widths
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 28;
  localparam int DIV_CW = 6;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_WIDTH = 2'd2;
  localparam logic [1:0] REG_K_GAIN       = 2'd3;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Divider request
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/sauvola_local_threshold.sv
// Sauvola adaptive binarization over a raster pixel stream, top level.
// A pixel transaction passes through S_IDLE and S_CHECK; when a result becomes ready the block
// sums each filled window column (one line store read per row, all columns at the start of a
// row), then runs the variance divide, the square root and the threshold divide. One transaction
// is in work at a time.
// Reset: synchronous rst clears positions and restores register defaults; no clearing pass.
module sauvola_local_threshold import slt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        foreground,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        frame_last
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CHECK   = 16'h0002,
    S_FSTART  = 16'h0004,
    S_FILL    = 16'h0008,
    S_SUBRD   = 16'h0010,
    S_SUBWAIT = 16'h0020,
    S_PXRD    = 16'h0040,
    S_MUL1    = 16'h0080,
    S_MUL2    = 16'h0100,
    S_DIV1    = 16'h0200,
    S_SQRT    = 16'h0400,
    S_FCALC   = 16'h0800,
    S_MUL3    = 16'h1000,
    S_DIV2GO  = 16'h2000,
    S_DIV2    = 16'h4000,
    S_OUT     = 16'h8000
  } state_t;

  state_t state;

  // Configuration
  logic [10:0] image_width, image_height;
  logic [6:0]  window_width;
  logic [8:0]  k_gain;

  // Positions
  logic [9:0] in_row, in_col, orow, ocol;
  logic       complete;

  // Window datapath
  logic [9:0]  colx;
  logic [10:0] fy;
  logic        rd_pend;
  logic [14:0] acc_s;
  logic [22:0] acc_q;
  logic [21:0] run_s;
  logic [29:0] run_q;
  logic [13:0] area;
  logic [7:0]  px;
  logic [43:0] p_aq, p_ss;
  logic [27:0] p_aa;
  logic [23:0] sq_v, sq_res, sq_bit;
  logic [3:0]  sq_cnt;
  logic [11:0] stdq;
  logic signed [22:0] f;
  logic [41:0] prod;
  logic [7:0]  thr;

  // Memories
  logic [7:0]  line_store [LS_DEPTH];
  logic [37:0] col_mem [MAX_WIDTH];
  logic [7:0]  ls_rdata;
  logic [37:0] cm_rdata;
  logic        ls_we, ls_re, cm_we, cm_re;
  logic [LS_AW-1:0] ls_raddr;

  // Divider
  div_req_t          div_req;
  logic              div_busy, div_done;
  logic [DIV_NW-1:0] div_quot;

  // Effective geometry
  logic [10:0] w_eff, h_eff;
  logic [9:0]  wm1, hm1;
  logic [5:0]  hw;
  logic [9:0]  ymin, ymax, xmin, xmax;
  logic [10:0] r_hi, c_hi;
  logic        ready_now, issue, fill_done, last;
  logic [23:0] sq_sum, sq_res_next;
  logic        sq_ge;
  logic [43:0] num;

  assign w_eff = (image_width == 11'd0) ? 11'd1 :
                 (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == 11'd0) ? 11'd1 :
                 (image_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : image_height;
  assign wm1 = 10'(w_eff - 11'd1);
  assign hm1 = 10'(h_eff - 11'd1);
  assign hw  = window_width[6:1];

  // Clamped window of the next result
  assign r_hi = {1'b0, orow} + {5'd0, hw};
  assign c_hi = {1'b0, ocol} + {5'd0, hw};
  assign ymin = (orow > {4'd0, hw}) ? 10'(orow - {4'd0, hw}) : 10'd0;
  assign xmin = (ocol > {4'd0, hw}) ? 10'(ocol - {4'd0, hw}) : 10'd0;
  assign ymax = (r_hi > {1'b0, hm1}) ? hm1 : r_hi[9:0];
  assign xmax = (c_hi > {1'b0, wm1}) ? wm1 : c_hi[9:0];

  assign ready_now = complete || (in_row > ymax) || (in_row == ymax && in_col > xmax);
  assign last      = (orow == hm1) && (ocol == wm1);

  // Column fill control
  assign issue     = fy <= {1'b0, ymax};
  assign fill_done = (state == S_FILL) && !issue && !rd_pend;

  // Square root step
  assign sq_sum      = sq_res + sq_bit;
  assign sq_ge       = sq_v >= sq_sum;
  assign sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  assign num = p_aq - p_ss;

  // Memory controls
  assign in_ready = (state == S_IDLE);
  assign ls_we    = in_ready && in_valid && (command == CMD_PIXEL) && !complete;
  assign ls_re    = ((state == S_FILL) && issue) || (state == S_PXRD);
  assign ls_raddr = (state == S_PXRD) ? {orow[6:0], ocol} : {fy[6:0], colx};
  assign cm_we    = fill_done;
  assign cm_re    = (state == S_SUBRD);

  always_ff @(posedge clk) begin
    if (ls_we) line_store[{in_row[6:0], in_col}] <= pixel;
    if (ls_re) ls_rdata <= line_store[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) col_mem[colx] <= {acc_s, acc_q};
    if (cm_re) cm_rdata <= col_mem[10'(ocol - {4'd0, hw} - 10'd1)];
  end

  // Divider requests
  always_comb begin
    div_req.start    = ((state == S_MUL2) && (area > 14'd1)) || (state == S_DIV2GO);
    div_req.dividend = (state == S_DIV2GO) ? DIV_NW'(prod[41:19]) : {num, 8'd0};
    div_req.divisor  = (state == S_DIV2GO) ? DIV_DW'(area) : p_aa;
  end

  slt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= 11'd640;
      image_height <= 11'd480;
      window_width <= 7'd31;
      k_gain       <= 9'd51;
      in_row       <= '0;
      in_col       <= '0;
      orow         <= '0;
      ocol         <= '0;
      complete     <= 1'b0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      // A result loaded in S_OUT takes the place of the one leaving
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;

      // Register write restarts the frame
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_WINDOW_WIDTH: window_width <= cfg_data[6:0];
          REG_K_GAIN:       k_gain       <= cfg_data[8:0];
          default:          k_gain       <= k_gain;
        endcase
        in_row   <= '0;
        in_col   <= '0;
        orow     <= '0;
        ocol     <= '0;
        complete <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (ls_we) begin
              if (in_col == wm1) begin
                in_col <= '0;
                if (in_row == hm1) complete <= 1'b1;
                else in_row <= in_row + 10'd1;
              end else begin
                in_col <= in_col + 10'd1;
              end
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!ready_now) begin
            state <= S_IDLE;
          end else if (ocol == 10'd0) begin
            run_s <= '0;
            run_q <= '0;
            colx  <= '0;
            state <= S_FSTART;
          end else if (c_hi <= {1'b0, wm1}) begin
            colx  <= c_hi[9:0];
            state <= S_FSTART;
          end else begin
            state <= S_SUBRD;
          end
        end
        S_FSTART: begin
          fy      <= {1'b0, ymin};
          rd_pend <= 1'b0;
          acc_s   <= '0;
          acc_q   <= '0;
          state   <= S_FILL;
        end
        S_FILL: begin
          rd_pend <= issue;
          if (issue) fy <= fy + 11'd1;
          if (rd_pend) begin
            acc_s <= acc_s + 15'(ls_rdata);
            acc_q <= acc_q + 23'({8'd0, ls_rdata} * {8'd0, ls_rdata});
          end
          if (fill_done) begin
            run_s <= run_s + 22'(acc_s);
            run_q <= run_q + 30'(acc_q);
            if (ocol == 10'd0 && colx < xmax) begin
              colx  <= colx + 10'd1;
              state <= S_FSTART;
            end else begin
              state <= S_SUBRD;
            end
          end
        end
        S_SUBRD: begin
          state <= (ocol > {4'd0, hw}) ? S_SUBWAIT : S_PXRD;
        end
        S_SUBWAIT: begin
          run_s <= run_s - 22'(cm_rdata[37:23]);
          run_q <= run_q - 30'(cm_rdata[22:0]);
          state <= S_PXRD;
        end
        S_PXRD: begin
          area  <= 7'(xmax - xmin + 10'd1) * 7'(ymax - ymin + 10'd1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          px    <= ls_rdata;
          p_aq  <= area * run_q;
          p_ss  <= run_s * run_s;
          p_aa  <= area * (area - 14'd1);
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (area > 14'd1) begin
            state <= S_DIV1;
          end else begin
            stdq  <= '0;
            state <= S_FCALC;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            sq_v   <= div_quot[23:0];
            sq_res <= '0;
            sq_bit <= 24'h400000;
            sq_cnt <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) sq_v <= sq_v - sq_sum;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 4'd1;
          if (sq_cnt == 4'd11) begin
            stdq  <= sq_res_next[11:0];
            state <= S_FCALC;
          end
        end
        S_FCALC: begin
          f <= 23'sd524288 + $signed({1'b0, k_gain}) * ($signed({1'b0, stdq}) - 13'sd2048);
          state <= S_MUL3;
        end
        S_MUL3: begin
          if (f[22] || f == 23'sd0) begin
            thr   <= '0;
            state <= S_OUT;
          end else begin
            prod  <= run_s * f[19:0];
            state <= S_DIV2GO;
          end
        end
        S_DIV2GO: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            thr   <= (div_quot > DIV_NW'(255)) ? 8'd255 : div_quot[7:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            foreground <= px < thr;
            out_row    <= orow;
            out_col    <= ocol;
            frame_last <= last;
            if (last) begin
              orow     <= '0;
              ocol     <= '0;
              in_row   <= '0;
              in_col   <= '0;
              complete <= 1'b0;
            end else if (ocol == wm1) begin
              ocol <= '0;
              orow <= orow + 10'd1;
            end else begin
              ocol <= ocol + 10'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_ls_write_idle: assert property (@(posedge clk) disable iff (rst)
    ls_we |-> !ls_re && state == S_IDLE)
    else $error("line store written during a result");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> out_valid && state == S_IDLE)
    else $error("result not loaded");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> div_busy && (state == S_DIV1 || state == S_DIV2))
    else $error("divider started outside a divide step");

endmodule

FILE: design/slt_div.sv
// Restoring divider, one quotient bit per cycle.
module slt_div import slt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW-1:0] divisor;
  logic              fits;

  // Trial subtraction
  assign rem_sh = {rem, quotient[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quotient <= req.dividend;
        divisor  <= req.divisor;
        rem      <= '0;
        cnt      <= DIV_CW'(DIV_NW);
        busy     <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DW'(rem_sh - {1'b0, divisor});
        end else begin
          rem <= rem_sh[DIV_DW-1:0];
        end
        quotient <= {quotient[DIV_NW-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Checks
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");

endmodule

FILE: sim/tb_sauvola_local_threshold.sv
// Self-checking testbench for the Sauvola local threshold block.
module tb_sauvola_local_threshold;
  import slt_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE = 40;

  typedef struct {
    logic       fg;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } binar_t;

  // Threshold predictor plus the queue of expected results
  class binar_scoreboard;
    byte unsigned    pix_ring[LS_DEPTH];
    int unsigned     col_s[MAX_WIDTH];
    int unsigned     col_q[MAX_WIDTH];
    int unsigned     in_pos, out_pos;
    bit              in_done;
    longint unsigned win_s, win_q;
    int unsigned     img_w, img_h, win_w, kg;
    int              frames_done;
    int              errors;
    binar_t          pending[$];

    function new();
      img_w = 640; img_h = 480; win_w = 31; kg = 51;
      restart();
    endfunction

    function void restart();
      in_pos = 0; out_pos = 0; in_done = 0; win_s = 0; win_q = 0;
    endfunction

    function int unsigned eff_w();
      return (img_w < 1) ? 1 : (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
    endfunction

    function int unsigned eff_h();
      return (img_h < 1) ? 1 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
    endfunction

    function int unsigned half();
      return ((win_w > MAX_WINDOW) ? MAX_WINDOW : win_w) >> 1;
    endfunction

    function int unsigned slot(int unsigned r, int unsigned c);
      return (r % RING_ROWS) * MAX_WIDTH + (c % MAX_WIDTH);
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  img_w = val;
        REG_IMAGE_HEIGHT: img_h = val;
        REG_WINDOW_WIDTH: win_w = val[6:0];
        REG_K_GAIN:       kg = val[8:0];
      endcase
      restart();
      pending.delete();
    endfunction

    function void sum_column(int unsigned x, int unsigned y0, int unsigned y1);
      int unsigned s, q, v;
      s = 0; q = 0;
      for (int unsigned y = y0; y <= y1; y++) begin
        v = pix_ring[slot(y, x)];
        s += v;
        q += v * v;
      end
      col_s[x % MAX_WIDTH] = s & 32'h7fff;
      col_q[x % MAX_WIDTH] = q & 32'h7fffff;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Window of the next result, clamped at the frame edges
    function bit result_due();
      int unsigned w, h, hw, r, c, ymax, xmax;
      w = eff_w(); h = eff_h(); hw = half();
      r = out_pos / w; c = out_pos % w;
      ymax = (r + hw > h - 1) ? h - 1 : r + hw;
      xmax = (c + hw > w - 1) ? w - 1 : c + hw;
      if (in_done) return 1;
      return in_pos > ymax * w + xmax;
    endfunction

    function void predict_result();
      int unsigned w, h, hw, r, c, ymin, ymax, xmin, xmax;
      longint unsigned area, sd, thr, num;
      longint f;
      binar_t e;
      w = eff_w(); h = eff_h(); hw = half();
      r = out_pos / w; c = out_pos % w;
      ymin = (r > hw) ? r - hw : 0;
      ymax = (r + hw > h - 1) ? h - 1 : r + hw;
      xmin = (c > hw) ? c - hw : 0;
      xmax = (c + hw > w - 1) ? w - 1 : c + hw;
      sd = 0;
      if (c == 0) begin
        win_s = 0; win_q = 0;
        for (int unsigned x = xmin; x <= xmax; x++) begin
          sum_column(x, ymin, ymax);
          win_s += col_s[x];
          win_q += col_q[x];
        end
      end else begin
        if (c + hw <= w - 1) begin
          sum_column(c + hw, ymin, ymax);
          win_s += col_s[c + hw];
          win_q += col_q[c + hw];
        end
        if (c > hw) begin
          win_s -= col_s[c - hw - 1];
          win_q -= col_q[c - hw - 1];
        end
      end
      area = longint'(xmax - xmin + 1) * longint'(ymax - ymin + 1);
      if (area > 1) begin
        num = area * win_q - win_s * win_s;
        sd = int_sqrt((num * 256) / (area * (area - 1)));
      end
      f = 524288 + longint'(kg) * (longint'(sd) - 2048);
      if (f <= 0) thr = 0;
      else begin
        thr = (win_s * longint'(f)) / (area * 524288);
        if (thr > 255) thr = 255;
      end
      e.fg = (longint'(pix_ring[slot(r, c)]) < thr);
      e.row = r[9:0];
      e.col = c[9:0];
      out_pos++;
      e.last = (out_pos >= w * h);
      pending.push_back(e);
      if (e.last) begin
        restart();
        frames_done++;
      end
    endfunction

    // Accepted input transaction
    function void note_input(logic cmd, logic [7:0] px);
      int unsigned w;
      if (cmd == CMD_PIXEL && !in_done) begin
        w = eff_w();
        pix_ring[slot(in_pos / w, in_pos % w)] = px;
        in_pos++;
        if (in_pos >= w * eff_h()) in_done = 1;
      end
      if (result_due()) predict_result();
    endfunction

    // Accepted result transaction
    function void check_result(logic fg, logic [9:0] row, logic [9:0] col, logic last);
      binar_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result row %0d col %0d", row, col);
        return;
      end
      e = pending.pop_front();
      if (fg !== e.fg || row !== e.row || col !== e.col || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp fg %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                   e.fg, e.row, e.col, e.last, fg, row, col, last);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid, in_ready, command;
  logic [7:0]  pixel;
  logic        out_valid, out_ready, foreground, frame_last;
  logic [9:0]  out_row, out_col;

  binar_scoreboard sb;
  int   n_items;
  bit   hold_req;
  bit   held;
  int   cycles;

  sauvola_local_threshold dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold, gap;
    out_ready = 0;
    hold = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(foreground, out_row, out_col, frame_last);
      if (hold_req) begin
        hold_req = 0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (rst) begin
        out_ready <= 0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        gap = pick_gap();
      end
    end
  end

  task automatic send_item(logic cmd, logic [7:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    pixel <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, px);
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [10:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic setup(int w, int h, int win, int k);
    write_cfg(REG_IMAGE_WIDTH, 11'(w));
    write_cfg(REG_IMAGE_HEIGHT, 11'(h));
    write_cfg(REG_WINDOW_WIDTH, 11'(win));
    write_cfg(REG_K_GAIN, 11'(k));
  endtask

  // One whole frame of random content, drains mixed in, until its last result
  task automatic run_frame(int drain_pct);
    int start;
    start = sb.frames_done;
    while (sb.frames_done == start) begin
      if ($urandom_range(0, 99) < drain_pct) send_item(CMD_DRAIN, 8'($urandom));
      else send_item(CMD_PIXEL, 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_we = 0; cfg_index = REG_IMAGE_WIDTH; cfg_data = 0;
    in_valid = 0; command = CMD_PIXEL; pixel = 0;
    hold_req = 0;
    held = 0;
    n_items = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: 3x2 frame, drain with nothing ready, pixel extremes, k = 0
    setup(3, 2, 3, 0);
    send_item(CMD_DRAIN, 8'hff);
    send_item(CMD_PIXEL, 8'h00);
    send_item(CMD_PIXEL, 8'hff);
    send_item(CMD_PIXEL, 8'h80);
    send_item(CMD_PIXEL, 8'h7f);
    send_item(CMD_PIXEL, 8'h01);
    send_item(CMD_PIXEL, 8'hfe);
    // pixels after the frame is in are discarded and act as drains
    send_item(CMD_PIXEL, 8'h55);
    repeat (6) send_item(CMD_DRAIN, 8'h00);
    wait_idle();

    // Single pixel frame: area one, zero width regs, largest gain
    setup(0, 0, 0, 511);
    send_item(CMD_PIXEL, 8'hc3);
    wait_idle();

    // Restart in the middle of a frame drops what is pending
    setup(4, 4, 127, 255);
    repeat (5) send_item(CMD_PIXEL, 8'($urandom));
    wait_idle();
    setup(5, 3, 5, 51);
    run_frame(0);
    wait_idle();

    // Random frames with random settings, one long result hold-off early on
    while (n_items < 150) begin
      setup($urandom_range(1, 12), $urandom_range(1, 10),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 9),
            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) * 511 : $urandom_range(0, 511));
      if (!held && n_items > 40) begin
        hold_req = 1;
        held = 1;
      end
      run_frame($urandom_range(0, 1) ? 0 : 15);
      wait_idle();
    end

    // Tallest frame, height clamped from an out-of-range value; the line ring wraps
    setup(1, 2047, 3, 0);
    run_frame(5);
    wait_idle();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/slt_pkg.sv
design/slt_div.sv
design/sauvola_local_threshold.sv
sim/tb_sauvola_local_threshold.sv
